FILE: hdl/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg: shared types and constants of the latency histogram
// Holds the bucket limit table, request codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lhp_pkg;

  localparam int TABLE_LEN = 109;
  localparam int SMP_W     = 64;
  localparam int PCT_W     = 14;
  localparam int PROD_W    = 78;   // 64-bit value times 10000
  localparam int HIT_W     = 7;
  localparam int FRAC_W    = 16;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef logic [SMP_W-1:0] limit_tab_t [TABLE_LEN];

  // Running value grows by 3/2 in 64.64 fixed point; keep leading digits up to 109.
  function automatic limit_tab_t build_limits();
    limit_tab_t  tab;
    logic [127:0] run;
    logic [63:0]  t;
    logic [63:0]  p;
    tab[0] = 64'd1;
    tab[1] = 64'd2;
    run = {64'd2, 64'd0};
    for (int i = 2; i < TABLE_LEN; i++) begin
      run = run + (run >> 1);
      t = run[127:64];
      p = 64'd1;
      for (int j = 0; j < 20; j++) begin
        if (t / 64'd10 > 64'd10) begin
          t = t / 64'd10;
          p = p * 64'd10;
        end
      end
      tab[i] = t * p;
    end
    return tab;
  endfunction

  localparam limit_tab_t LIMIT_TAB = build_limits();

  // x * 10000 as a sum of shifted copies
  function automatic logic [PROD_W-1:0] mul10k(input logic [SMP_W-1:0] x);
    logic [PROD_W-1:0] xe;
    xe = PROD_W'(x);
    return (xe << 13) + (xe << 10) + (xe << 9) + (xe << 8) + (xe << 4);
  endfunction

  typedef struct packed {
    logic capture;
    logic clear;
    logic sq0;
    logic sq1;
    logic srch;
    logic add_rd;
    logic add_wr;
    logic thr0;
    logic thr1;
    logic walk_rd;
    logic walk_acc;
    logic walk_mul;
    logic walk_next;
    logic f_ls;
    logic f_dd;
    logic f_w;
    logic mul;
    logic div_init;
    logic div;
    logic fin_hit;
    logic fin_miss;
  } lhp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic walk_hit;
    logic walk_last;
    logic bv_zero;
    logic mul_last;
    logic div_last;
  } lhp_sts_t;

endpackage

`default_nettype wire

FILE: hdl/lhp_ctrl.sv
// ----------------------------------------------------------------------------
// lhp_ctrl: sequencer of the latency histogram
// Steps the datapath through add, clear and percentile query transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_ctrl
  import lhp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic [1:0] req_type_i,
  input  wire lhp_sts_t   sts_i,
  output logic            busy,
  output logic            done_o,
  output lhp_cmd_t        cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ0, ST_SQ1, ST_SRCH, ST_ARD, ST_AWR, ST_CLR,
    ST_T0, ST_T1, ST_WRD, ST_WACC, ST_WMUL, ST_WTST,
    ST_FLS, ST_FDD, ST_FW, ST_MUL, ST_DINIT, ST_DIV, ST_FIN
  } state_e;

  state_e state_q;
  logic   done_q;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = (state_q == ST_IDLE) && start;
    cmd_o.clear     = (state_q == ST_CLR);
    cmd_o.sq0       = (state_q == ST_SQ0);
    cmd_o.sq1       = (state_q == ST_SQ1);
    cmd_o.srch      = (state_q == ST_SRCH) && !sts_i.srch_done;
    cmd_o.add_rd    = (state_q == ST_ARD);
    cmd_o.add_wr    = (state_q == ST_AWR);
    cmd_o.thr0      = (state_q == ST_T0);
    cmd_o.thr1      = (state_q == ST_T1);
    cmd_o.walk_rd   = (state_q == ST_WRD);
    cmd_o.walk_acc  = (state_q == ST_WACC);
    cmd_o.walk_mul  = (state_q == ST_WMUL);
    cmd_o.walk_next = (state_q == ST_WTST) && !sts_i.walk_hit && !sts_i.walk_last;
    cmd_o.fin_miss  = (state_q == ST_WTST) && !sts_i.walk_hit && sts_i.walk_last;
    cmd_o.f_ls      = (state_q == ST_FLS);
    cmd_o.f_dd      = (state_q == ST_FDD);
    cmd_o.f_w       = (state_q == ST_FW);
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.div_init  = (state_q == ST_DINIT);
    cmd_o.div       = (state_q == ST_DIV);
    cmd_o.fin_hit   = (state_q == ST_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            priority case (req_type_i)
              REQ_ADD:   state_q <= ST_SQ0;
              REQ_CLEAR: state_q <= ST_CLR;
              REQ_QUERY: state_q <= ST_T0;
              default:   done_q  <= 1'b1;
            endcase
          end
        end
        ST_SQ0:  state_q <= ST_SQ1;
        ST_SQ1:  state_q <= ST_SRCH;
        ST_SRCH: begin
          if (sts_i.srch_done) state_q <= ST_ARD;
        end
        ST_ARD:  state_q <= ST_AWR;
        ST_AWR: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        ST_CLR: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        ST_T0:   state_q <= ST_T1;
        ST_T1:   state_q <= ST_WRD;
        ST_WRD:  state_q <= ST_WACC;
        ST_WACC: state_q <= ST_WMUL;
        ST_WMUL: state_q <= ST_WTST;
        ST_WTST: begin
          if (sts_i.walk_hit) begin
            state_q <= ST_FLS;
          end else if (sts_i.walk_last) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= ST_WRD;
          end
        end
        ST_FLS:  state_q <= ST_FDD;
        ST_FDD:  state_q <= ST_FW;
        ST_FW:   state_q <= sts_i.bv_zero ? ST_FIN : ST_MUL;
        ST_MUL: begin
          if (sts_i.mul_last) state_q <= ST_DINIT;
        end
        ST_DINIT: state_q <= ST_DIV;
        ST_DIV: begin
          if (sts_i.div_last) state_q <= ST_FIN;
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lhp_dp.sv
// ----------------------------------------------------------------------------
// lhp_dp: datapath of the latency histogram
// Bucket memory, running statistics, bucket search and percentile arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module lhp_dp
  import lhp_pkg::*;
#(
  parameter int NUM_BUCKETS = 109,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lhp_cmd_t          cmd_i,
  input  wire logic [SMP_W-1:0]  sample_value_i,
  input  wire logic [PCT_W-1:0]  pct_hundredths_i,
  output lhp_sts_t               sts_o,
  output logic [SMP_W-1:0]       sample_count_o,
  output logic [SMP_W-1:0]       sample_sum_o,
  output logic [SMP_W-1:0]       square_sum_o,
  output logic [SMP_W-1:0]       min_seen_o,
  output logic [SMP_W-1:0]       max_seen_o,
  output logic [HIT_W-1:0]       bucket_hit_o,
  output logic [SMP_W-1:0]       pct_integer_o,
  output logic [FRAC_W-1:0]      pct_fraction_o
);

  localparam int IW  = $clog2(NUM_BUCKETS);
  localparam int QW  = SMP_W + FRAC_BITS;
  localparam int AW  = PROD_W + SMP_W;
  localparam logic [IW-1:0]    LAST_IDX = IW'(NUM_BUCKETS - 1);
  localparam logic [SMP_W-1:0] TOP      = LIMIT_TAB[NUM_BUCKETS-1];
  localparam logic [QW-1:0]    FMASK    = (QW'(1) << FRAC_BITS) - QW'(1);

  // bucket memory with per-entry valid bits
  logic [SMP_W-1:0]       mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] vld_q;
  logic [SMP_W-1:0]       rdata_q;
  logic                   rvld_q;
  logic [SMP_W-1:0]       rd_val;
  logic [IW-1:0]          rd_addr;

  // statistics
  logic [SMP_W-1:0] cnt_q, sum_q, sq_q, min_q, max_q;

  // item and working registers
  logic [SMP_W-1:0]  v_q;
  logic [PCT_W-1:0]  ph_q;
  logic [IW-1:0]     lo_q, hi_q, b_q;
  logic [63:0]       p0_q, p1_q;
  logic [PROD_W-1:0] thr_q, c_q, ls_q, dd_q, nn_q;
  logic [SMP_W-1:0]  cum_q, bv_q, w_q, left_q;
  logic [AW-1:0]     acc_q;
  logic [PROD_W-1:0] rem_q;
  logic [QW-1:0]     quo_q;
  logic [6:0]        k_q;

  // results
  logic [HIT_W-1:0]  hit_q;
  logic [SMP_W-1:0]  ip_q;
  logic [FRAC_W-1:0] fp_q;

  // combinational helpers
  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [45:0]        thr_p;
  logic [PROD_W:0]    r2;
  logic               ge;
  logic [SMP_W-1:0]   fin_ip;
  logic [QW-1:0]      fin_fp;

  assign rd_addr = cmd_i.walk_rd ? b_q : lo_q;
  assign rd_val  = rvld_q ? rdata_q : '0;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];
  assign mul_b   = cmd_i.sq1 ? v_q[63:32] : v_q[31:0];
  assign mul_p   = v_q[31:0] * mul_b;
  assign thr_p   = (cmd_i.thr0 ? cnt_q[31:0] : cnt_q[63:32]) * ph_q;
  assign r2      = {rem_q, acc_q[AW-1]};
  assign ge      = (r2 >= {1'b0, dd_q});
  assign fin_ip  = SMP_W'(quo_q >> FRAC_BITS) + left_q;
  assign fin_fp  = quo_q & FMASK;

  assign sts_o.srch_done = (lo_q == hi_q);
  assign sts_o.walk_hit  = (c_q >= thr_q);
  assign sts_o.walk_last = (b_q == LAST_IDX);
  assign sts_o.bv_zero   = (bv_q == '0);
  assign sts_o.mul_last  = (k_q == 7'd63);
  assign sts_o.div_last  = (k_q == 7'(QW - 1));

  // memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_rd || cmd_i.walk_rd) rdata_q <= mem[rd_addr];
    if (cmd_i.add_wr) mem[lo_q] <= rd_val + 64'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      min_q  <= TOP;
      max_q  <= '0;
    end else begin
      if (cmd_i.add_rd || cmd_i.walk_rd) rvld_q <= vld_q[rd_addr];
      if (cmd_i.clear) begin
        vld_q <= '0;
        cnt_q <= '0;
        sum_q <= '0;
        sq_q  <= '0;
        min_q <= TOP;
        max_q <= '0;
      end else if (cmd_i.add_wr) begin
        vld_q[lo_q] <= 1'b1;
        cnt_q <= cnt_q + 64'd1;
        sum_q <= sum_q + v_q;
        sq_q  <= sq_q + p0_q + {p1_q[30:0], 33'd0};
        if (v_q < min_q) min_q <= v_q;
        if (v_q > max_q) max_q <= v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      v_q   <= sample_value_i;
      ph_q  <= pct_hundredths_i;
      lo_q  <= (sample_value_i >= TOP) ? LAST_IDX : '0;
      hi_q  <= LAST_IDX;
      hit_q <= '0;
      ip_q  <= '0;
      fp_q  <= '0;
    end
    if (cmd_i.sq0) p0_q <= mul_p;
    if (cmd_i.sq1) p1_q <= mul_p;
    // lower-bound binary search over the limit table
    if (cmd_i.srch) begin
      if (LIMIT_TAB[mid] < v_q) lo_q <= mid + 1'b1;
      else                      hi_q <= mid;
    end
    if (cmd_i.add_wr) hit_q <= HIT_W'(lo_q);
    // threshold count * pct in two halves
    if (cmd_i.thr0) begin
      thr_q <= PROD_W'(thr_p);
      b_q   <= '0;
      cum_q <= '0;
    end
    if (cmd_i.thr1) thr_q <= thr_q + {thr_p[PROD_W-33:0], 32'd0};
    if (cmd_i.walk_acc) begin
      cum_q <= cum_q + rd_val;
      bv_q  <= rd_val;
    end
    if (cmd_i.walk_mul)  c_q <= mul10k(cum_q);
    if (cmd_i.walk_next) b_q <= b_q + 1'b1;
    if (cmd_i.f_ls) ls_q <= mul10k(cum_q - bv_q);
    if (cmd_i.f_dd) begin
      dd_q <= mul10k(bv_q);
      nn_q <= (thr_q > ls_q) ? thr_q - ls_q : '0;
    end
    if (cmd_i.f_w) begin
      if (nn_q > dd_q) nn_q <= dd_q;
      w_q    <= LIMIT_TAB[b_q] - ((b_q == '0) ? '0 : LIMIT_TAB[b_q - 1'b1]);
      left_q <= (b_q == '0) ? '0 : LIMIT_TAB[b_q - 1'b1];
      acc_q  <= '0;
      quo_q  <= '0;
      k_q    <= '0;
    end
    // shift-add multiply, one bit of width per cycle
    if (cmd_i.mul) begin
      acc_q <= (acc_q << 1) + (w_q[SMP_W-1] ? AW'(nn_q) : '0);
      w_q   <= w_q << 1;
      k_q   <= k_q + 7'd1;
    end
    if (cmd_i.div_init) begin
      rem_q <= acc_q[AW-1:SMP_W];
      acc_q <= acc_q << PROD_W;
      k_q   <= '0;
    end
    // restoring division, one quotient bit per cycle
    if (cmd_i.div) begin
      rem_q <= ge ? PROD_W'(r2 - {1'b0, dd_q}) : r2[PROD_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
      acc_q <= acc_q << 1;
      k_q   <= k_q + 7'd1;
    end
    if (cmd_i.fin_hit) begin
      if (fin_ip < min_q) begin
        if (min_q > max_q) begin
          ip_q <= max_q;
        end else begin
          ip_q <= min_q;
        end
        fp_q <= '0;
      end else if (fin_ip > max_q || (fin_ip == max_q && fin_fp != '0)) begin
        ip_q <= max_q;
        fp_q <= '0;
      end else begin
        ip_q <= fin_ip;
        fp_q <= FRAC_W'(fin_fp);
      end
    end
    if (cmd_i.fin_miss) begin
      ip_q <= max_q;
      fp_q <= '0;
    end
  end

  assign sample_count_o = cnt_q;
  assign sample_sum_o   = sum_q;
  assign square_sum_o   = sq_q;
  assign min_seen_o     = min_q;
  assign max_seen_o     = max_q;
  assign bucket_hit_o   = hit_q;
  assign pct_integer_o  = ip_q;
  assign pct_fraction_o = fp_q;

endmodule

`default_nettype wire

FILE: hdl/latency_histogram_percentile.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile: bucketed sample histogram with percentile query
// Counts 64-bit samples into fixed log-spaced buckets and interpolates
// percentiles on request.
// ----------------------------------------------------------------------------
// Usage: drive req_type_i, sample_value_i and pct_hundredths_i and raise
// start; a transaction is taken at a clock edge with start high and busy
// low. Each transaction gives one result, shown for exactly one cycle with
// valid_o high; the receiver cannot stall it, so sample it then.
// Steps from acceptance to valid_o:
//   add   : squaring, the binary bucket search, bucket read and write
//   clear : the clear step
//   query : threshold steps, a read, accumulate, scale and test per bucket
//           walked, then setup, 64 multiply, (64 + FRAC_BITS) divide and a
//           final step at a filled bucket, or setup and final at an empty one
//   code 3: statistics only
// The bucket walk and the bit-serial multiply and divide set the query time;
// the bucket search and memory read-modify-write set the add time. A new
// transaction may start in the cycle valid_o is high.
// Reset clears all buckets at once through per-bucket valid bits, zeroes
// the statistics and sets the minimum to the top bucket limit.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_percentile
  import lhp_pkg::*;
#(
  parameter int NUM_BUCKETS = 109,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [SMP_W-1:0]  sample_value_i,
  input  wire logic [PCT_W-1:0]  pct_hundredths_i,
  output logic                   valid_o,
  output logic [SMP_W-1:0]       sample_count_o,
  output logic [SMP_W-1:0]       sample_sum_o,
  output logic [SMP_W-1:0]       square_sum_o,
  output logic [SMP_W-1:0]       min_seen_o,
  output logic [SMP_W-1:0]       max_seen_o,
  output logic [HIT_W-1:0]       bucket_hit_o,
  output logic [SMP_W-1:0]       pct_integer_o,
  output logic [FRAC_W-1:0]      pct_fraction_o
);

  // command and status between sequencer and datapath
  lhp_cmd_t cmd;
  lhp_sts_t sts;

  // sequencer: one state per datapath step
  lhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .busy       (busy),
    .done_o     (valid_o),
    .cmd_o      (cmd)
  );

  // datapath: bucket memory, statistics and percentile arithmetic
  lhp_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sample_value_i   (sample_value_i),
    .pct_hundredths_i (pct_hundredths_i),
    .sts_o            (sts),
    .sample_count_o   (sample_count_o),
    .sample_sum_o     (sample_sum_o),
    .square_sum_o     (square_sum_o),
    .min_seen_o       (min_seen_o),
    .max_seen_o       (max_seen_o),
    .bucket_hit_o     (bucket_hit_o),
    .pct_integer_o    (pct_integer_o),
    .pct_fraction_o   (pct_fraction_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/latency_histogram_percentile_tb.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile_tb: self-checking bench for the histogram
// Sends add, clear, query and unused-code transactions on the start/busy
// handshake. A local model of the bucket table and statistics predicts each
// result, and the monitor compares every strobed result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_percentile_tb;
  import lhp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          N_BINS     = 109;
  localparam int          FRAC_BITS  = 16;
  localparam int          N_RANDOM   = 1000;
  localparam int          CYCLE_CAP  = 3000000;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;

  // One pending transaction; a drain entry holds the sender until all
  // outstanding results have come back.
  typedef struct {
    logic             drain;
    logic [1:0]       req;
    logic [SMP_W-1:0] sample;
    logic [PCT_W-1:0] pct;
  } txn_t;

  typedef struct {
    logic [SMP_W-1:0]  count;
    logic [SMP_W-1:0]  sum;
    logic [SMP_W-1:0]  sq_sum;
    logic [SMP_W-1:0]  min_v;
    logic [SMP_W-1:0]  max_v;
    logic [HIT_W-1:0]  hit;
    logic [SMP_W-1:0]  p_int;
    logic [FRAC_W-1:0] p_frac;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start;
  logic busy;
  logic [1:0] req_type_i;
  logic [SMP_W-1:0] sample_value_i;
  logic [PCT_W-1:0] pct_hundredths_i;
  logic valid_o;
  logic [SMP_W-1:0] sample_count_o, sample_sum_o, square_sum_o, min_seen_o, max_seen_o;
  logic [HIT_W-1:0] bucket_hit_o;
  logic [SMP_W-1:0] pct_integer_o;
  logic [FRAC_W-1:0] pct_fraction_o;

  txn_t   pending_txns[$];
  stats_t expected_stats[$];

  // Local histogram model
  logic [SMP_W-1:0] bin_limit [N_BINS];
  logic [SMP_W-1:0] bin_count [N_BINS];
  logic [SMP_W-1:0] m_count, m_sum, m_sq, m_min, m_max;

  int errors;
  int n_sent, n_total, n_checked;
  int n_add, n_clear, n_query, n_unused;
  int cycles;

  latency_histogram_percentile #(
    .NUM_BUCKETS(N_BINS),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .sample_value_i  (sample_value_i),
    .pct_hundredths_i(pct_hundredths_i),
    .valid_o         (valid_o),
    .sample_count_o  (sample_count_o),
    .sample_sum_o    (sample_sum_o),
    .square_sum_o    (square_sum_o),
    .min_seen_o      (min_seen_o),
    .max_seen_o      (max_seen_o),
    .bucket_hit_o    (bucket_hit_o),
    .pct_integer_o   (pct_integer_o),
    .pct_fraction_o  (pct_fraction_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Grow a 64.64 running value by 3/2 and keep its leading decimal digits, up to 109.
  task automatic build_bin_limits();
    logic [127:0] run;
    logic [63:0] t, p;
    bin_limit[0] = 64'd1;
    bin_limit[1] = 64'd2;
    run = {64'd2, 64'd0};
    for (int i = 2; i < N_BINS; i++) begin
      run = run + (run >> 1);
      t = run[127:64];
      p = 64'd1;
      while (t / 64'd10 > 64'd10) begin
        t = t / 64'd10;
        p = p * 64'd10;
      end
      bin_limit[i] = t * p;
    end
  endtask

  task automatic clear_histogram();
    for (int i = 0; i < N_BINS; i++) bin_count[i] = '0;
    m_count = '0;
    m_sum = '0;
    m_sq = '0;
    m_max = '0;
    m_min = bin_limit[N_BINS-1];
  endtask

  // Append one transaction to the stimulus list.
  task automatic queue_txn(input txn_t t);
    pending_txns = {pending_txns, t};
  endtask

  // Interpolated percentile, exact on wide integers, then clamped to [min,max].
  task automatic interpolate_percentile(input logic [PCT_W-1:0] pct,
                                        output logic [63:0] ip, output logic [63:0] fp);
    logic [255:0] thr, c, ls, nn, dd, rem, span;
    logic [63:0] cum, bv, left, right;
    bit found;
    found = 0;
    thr = 256'(m_count) * 256'(pct);
    cum = '0;
    ip = m_max;
    fp = '0;
    for (int b = 0; b < N_BINS && !found; b++) begin
      bv = bin_count[b];
      cum = cum + bv;
      c = 256'(cum) * 256'd10000;
      if (c >= thr) begin
        found = 1;
        left = (b != 0) ? bin_limit[b-1] : 64'd0;
        right = bin_limit[b];
        ip = '0;
        fp = '0;
        if (bv != 0) begin
          ls = 256'(64'(cum - bv)) * 256'd10000;
          nn = (thr > ls) ? thr - ls : 256'd0;
          dd = 256'(bv) * 256'd10000;
          if (nn > dd) nn = dd;
          span = 256'(right - left);
          nn = nn * span;
          ip = 64'(nn / dd);
          rem = (nn % dd) << FRAC_BITS;
          fp = 64'(rem / dd);
        end
        ip = ip + left;
        if (ip < m_min) begin
          ip = m_min;
          fp = '0;
        end
        if (ip > m_max || (ip == m_max && fp != 0)) begin
          ip = m_max;
          fp = '0;
        end
      end
    end
  endtask

  // Apply one transaction to the model and return its expected result.
  task automatic apply_histogram_txn(input txn_t tx, output stats_t r);
    int idx;
    logic [63:0] ip, fp;
    idx = 0;
    ip = '0;
    fp = '0;
    case (tx.req)
      REQ_ADD: begin
        if (tx.sample >= bin_limit[N_BINS-1]) idx = N_BINS - 1;
        else while (idx < N_BINS - 1 && bin_limit[idx] < tx.sample) idx++;
        bin_count[idx] = bin_count[idx] + 1;
        if (tx.sample < m_min) m_min = tx.sample;
        if (tx.sample > m_max) m_max = tx.sample;
        m_count = m_count + 1;
        m_sum = m_sum + tx.sample;
        m_sq = m_sq + tx.sample * tx.sample;
        n_add++;
      end
      REQ_CLEAR: begin
        clear_histogram();
        n_clear++;
      end
      REQ_QUERY: begin
        interpolate_percentile(tx.pct, ip, fp);
        n_query++;
      end
      default: n_unused++;
    endcase
    r.count = m_count;
    r.sum = m_sum;
    r.sq_sum = m_sq;
    r.min_v = m_min;
    r.max_v = m_max;
    r.hit = HIT_W'(idx);
    r.p_int = ip;
    r.p_frac = fp[FRAC_W-1:0];
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, field, got, want);
    errors++;
  endtask

  // Samples that hit interesting places: zero, bucket edges, wrap-prone values.
  function automatic logic [63:0] pick_sample();
    int k;
    logic [63:0] v;
    k = $urandom_range(0, 9);
    case (k)
      0: v = 64'd0;
      1, 2: v = 64'($urandom_range(0, 300));
      3, 4: begin
        v = bin_limit[$urandom_range(0, N_BINS-1)];
        v = v + 64'($urandom_range(0, 2)) - 64'd1;
      end
      5: v = {$urandom, $urandom};
      6: v = '1;
      7: v = 64'($urandom);
      default: v = 64'($urandom_range(0, 100000));
    endcase
    return v;
  endfunction

  function automatic txn_t make_txn(input logic [1:0] req, input logic [63:0] s,
                                    input logic [PCT_W-1:0] p);
    txn_t t;
    t.drain = 1'b0;
    t.req = req;
    t.sample = s;
    t.pct = p;
    return t;
  endfunction

  function automatic txn_t drain_marker();
    txn_t t;
    t = make_txn(REQ_UNUSED, '0, '0);
    t.drain = 1'b1;
    return t;
  endfunction

  // Driver: advance on acceptance, hold while busy, idle at random except
  // in a quiet window in the middle of the run.
  always @(posedge clk_i) begin
    stats_t r;
    txn_t tx;
    bit idle_ok;
    cycles <= cycles + 1;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        tx = make_txn(req_type_i, sample_value_i, pct_hundredths_i);
        apply_histogram_txn(tx, r);
        expected_stats = {expected_stats, r};
        n_sent++;
      end
      if (!(start && busy)) begin
        idle_ok = !(n_sent >= 400 && n_sent < 600);
        if (pending_txns.size() > 0 && pending_txns[0].drain) begin
          // Hold off until every outstanding transaction has returned.
          if (expected_stats.size() == 0) void'(pending_txns.pop_front());
          start <= 1'b0;
        end else if (pending_txns.size() > 0 && !(idle_ok && $urandom_range(0, 99) < 22)) begin
          tx = pending_txns.pop_front();
          req_type_i <= tx.req;
          sample_value_i <= tx.sample;
          pct_hundredths_i <= tx.pct;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && valid_o) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("result with nothing outstanding", 64'd1, 64'd0);
      end else begin
        e = expected_stats.pop_front();
        n_checked++;
        if (sample_count_o !== e.count) report_mismatch("sample_count", sample_count_o, e.count);
        if (sample_sum_o !== e.sum) report_mismatch("sample_sum", sample_sum_o, e.sum);
        if (square_sum_o !== e.sq_sum) report_mismatch("square_sum", square_sum_o, e.sq_sum);
        if (min_seen_o !== e.min_v) report_mismatch("min_seen", min_seen_o, e.min_v);
        if (max_seen_o !== e.max_v) report_mismatch("max_seen", max_seen_o, e.max_v);
        if (bucket_hit_o !== e.hit) report_mismatch("bucket_hit", 64'(bucket_hit_o), 64'(e.hit));
        if (pct_integer_o !== e.p_int) report_mismatch("pct_integer", pct_integer_o, e.p_int);
        if (pct_fraction_o !== e.p_frac)
          report_mismatch("pct_fraction", 64'(pct_fraction_o), 64'(e.p_frac));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    logic [1:0] req;
    logic [PCT_W-1:0] pct;
    start = 1'b0;
    req_type_i = REQ_ADD;
    sample_value_i = '0;
    pct_hundredths_i = '0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_add = 0;
    n_clear = 0;
    n_query = 0;
    n_unused = 0;
    cycles = 0;
    build_bin_limits();
    clear_histogram();

    // Directed: empty queries, field extremes, bucket edges, unused code,
    // percentile above 100 percent, clear, then re-fill.
    queue_txn(make_txn(REQ_QUERY, '0, 14'd5000));
    queue_txn(make_txn(REQ_UNUSED, '1, '1));
    queue_txn(make_txn(REQ_ADD, 64'd0, '0));
    queue_txn(make_txn(REQ_ADD, '1, '1));
    queue_txn(make_txn(REQ_ADD, bin_limit[N_BINS-1], '0));
    queue_txn(make_txn(REQ_ADD, bin_limit[N_BINS-1] - 64'd1, '0));
    queue_txn(make_txn(REQ_ADD, 64'd1, '0));
    queue_txn(make_txn(REQ_ADD, 64'd3, '0));
    queue_txn(make_txn(REQ_ADD, bin_limit[40], '0));
    queue_txn(make_txn(REQ_ADD, bin_limit[40] + 64'd1, '0));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd0));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd10000));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd16383));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd10001));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd2500));
    queue_txn(make_txn(REQ_CLEAR, '1, '1));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd10000));
    queue_txn(make_txn(REQ_ADD, 64'd57, '0));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd5000));
    queue_txn(make_txn(REQ_QUERY, '0, 14'd1));

    // Random mix, mostly adds so the histogram fills up between rare clears.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 250 || i == 700) queue_txn(drain_marker());
      k = $urandom_range(0, 99);
      if (k < 72) req = REQ_ADD;
      else if (k < 95) req = REQ_QUERY;
      else if (k < 97) req = REQ_CLEAR;
      else req = REQ_UNUSED;
      k = $urandom_range(0, 9);
      if (k == 0) pct = 14'd0;
      else if (k == 1) pct = 14'd10000;
      else if (k == 2) pct = 14'($urandom_range(10001, 16383));
      else pct = 14'($urandom_range(0, 10000));
      queue_txn(make_txn(req, pick_sample(), pct));
    end
    n_total = pending_txns.size() - 2;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(n_sent == n_total && expected_stats.size() == 0)) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_stats.size() != 0) begin
      report_mismatch("results never arrived", 64'(expected_stats.size()), 64'd0);
    end

    $display("Covered %0d adds, %0d queries, %0d clears, %0d unused-code transactions",
             n_add, n_query, n_clear, n_unused);
    $display("Checked %0d results in %0d cycles, %0d mismatches", n_checked, cycles, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: latency_histogram_percentile.f
hdl/lhp_pkg.sv
hdl/lhp_ctrl.sv
hdl/lhp_dp.sv
hdl/latency_histogram_percentile.sv
tb/sv/latency_histogram_percentile_tb.sv
